// ----- hdl/swpf_pkg.sv -----
// Package with the types and constants shared by the sync-write packet framer.
package swpf_pkg;

  // Input operation codes.
  typedef enum logic {
    OP_START = 1'b0,
    OP_ENTRY = 1'b1
  } op_e;

  localparam logic [7:0] HEADER_BYTE  = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;
  localparam logic [7:0] INSTR_SYNC   = 8'h83;
  localparam logic [7:0] DATA_LEN     = 8'h02;

  localparam int unsigned MaxBytes = 8;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // One burst of bytes caused by a single input item.
  typedef struct packed {
    logic                          valid;
    logic                          closes;
    logic [IdxW-1:0]               last_idx;
    logic [MaxBytes-1:0][7:0]      bytes;
  } burst_t;

endpackage

// ----- hdl/swpf_framer.sv -----
// Packet framing logic: state registers and the byte burst built for one input item.
module swpf_framer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            operation_i,
  input  logic [6:0]      servo_count_i,
  input  logic [7:0]      reg_address_i,
  input  logic [7:0]      servo_id_i,
  input  logic [15:0]     data_value_i,
  output swpf_pkg::burst_t burst_o
);
  import swpf_pkg::*;

  logic [7:0] sum_q, sum_d;
  logic [6:0] left_q, left_d;

  logic [8:0] len_wide;
  logic [7:0] len;
  logic [7:0] start_sum;
  logic [7:0] entry_sum;
  logic [6:0] left_dec;

  always_comb begin
    len_wide  = {1'b0, servo_count_i, 1'b0} + {2'b00, servo_count_i} + 9'd4;
    len       = len_wide[7:0];
    start_sum = BROADCAST_ID + len + INSTR_SYNC + reg_address_i + DATA_LEN;
    entry_sum = sum_q + servo_id_i + data_value_i[15:8] + data_value_i[7:0];
    left_dec  = left_q - 7'd1;

    sum_d   = sum_q;
    left_d  = left_q;
    burst_o = '0;

    if (op_e'(operation_i) == OP_START) begin
      burst_o.valid    = 1'b1;
      burst_o.closes   = (servo_count_i == 7'd0);
      burst_o.last_idx = burst_o.closes ? IdxW'(7) : IdxW'(6);
      burst_o.bytes[0] = HEADER_BYTE;
      burst_o.bytes[1] = HEADER_BYTE;
      burst_o.bytes[2] = BROADCAST_ID;
      burst_o.bytes[3] = len;
      burst_o.bytes[4] = INSTR_SYNC;
      burst_o.bytes[5] = reg_address_i;
      burst_o.bytes[6] = DATA_LEN;
      burst_o.bytes[7] = ~start_sum;
      sum_d  = burst_o.closes ? 8'h00 : start_sum;
      left_d = servo_count_i;
    end else if (left_q != 7'd0) begin
      burst_o.valid    = 1'b1;
      burst_o.closes   = (left_dec == 7'd0);
      burst_o.last_idx = burst_o.closes ? IdxW'(3) : IdxW'(2);
      burst_o.bytes[0] = servo_id_i;
      burst_o.bytes[1] = data_value_i[15:8];
      burst_o.bytes[2] = data_value_i[7:0];
      burst_o.bytes[3] = ~entry_sum;
      sum_d  = burst_o.closes ? 8'h00 : entry_sum;
      left_d = left_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= 8'h00;
      left_q <= 7'd0;
    end else if (accept_i) begin
      sum_q  <= sum_d;
      left_q <= left_d;
    end
  end

endmodule

// ----- hdl/swpf_serializer.sv -----
// Output shift register that sends a burst one byte per transfer.
module swpf_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  swpf_pkg::burst_t burst_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       tx_byte_o,
  output logic             run_last_o,
  output logic             packet_end_o
);
  import swpf_pkg::*;

  logic                     busy_q, busy_d;
  logic                     closes_q, closes_d;
  logic [IdxW-1:0]          left_q, left_d;
  logic [MaxBytes-1:0][7:0] data_q, data_d;
  logic                     xfer;
  logic                     last;

  assign last         = (left_q == '0);
  assign xfer         = busy_q && !out_stall_i;
  assign can_load_o   = !busy_q || (xfer && last);
  assign out_valid_o  = busy_q;
  assign tx_byte_o    = data_q[0];
  assign run_last_o   = last;
  assign packet_end_o = last && closes_q;

  always_comb begin
    busy_d   = busy_q;
    closes_d = closes_q;
    left_d   = left_q;
    data_d   = data_q;
    if (xfer) begin
      busy_d = !last;
      left_d = left_q - IdxW'(1);
      data_d = {8'h00, data_q[MaxBytes-1:1]};
    end
    if (load_i && burst_i.valid) begin
      busy_d   = 1'b1;
      closes_d = burst_i.closes;
      left_d   = burst_i.last_idx;
      data_d   = burst_i.bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    closes_q <= closes_d;
    left_q   <= left_d;
    data_q   <= data_d;
  end

  // A burst is only loaded when the previous one is gone or leaves now.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && burst_i.valid |-> can_load_o)
    else $error("burst loaded over a pending one");

  // A loaded burst is on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && burst_i.valid |=> busy_q && tx_byte_o == $past(burst_i.bytes[0]))
    else $error("loaded burst not presented");

  // The serializer drains only after its final byte moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(xfer && last) |=> busy_q)
    else $error("burst dropped before its last byte");

endmodule

// ----- hdl/sync_write_packet_framer_unit.sv -----
// Top level of the servo-bus sync-write packet framer.
//
// The input channel takes one item per transfer: a start item (operation 0)
// with the servo count and register address, or an entry item (operation 1)
// with a servo id and a 16-bit value. The output channel moves one packet
// byte per transfer, with run_last marking the final byte of an item and
// packet_end marking the checksum byte.
// A start item produces seven header bytes, or eight when the count is zero
// and the checksum follows at once. An entry item produces three bytes, or
// four when it is the last announced entry. An entry with no packet open
// produces nothing, and a new start abandons any open packet.
// The framing logic builds the whole burst in the cycle of the input
// transfer, and its first byte is on the output in the next cycle. The
// output shift register sends one byte per cycle while the receiver does
// not stall; the next item is taken in the same cycle as the last byte of
// the current one. When the receiver stalls, the current byte holds and
// in_stall_o rises as soon as the shift register cannot take another burst.
// Reset clears the running checksum, closes any packet and empties the
// output, so out_valid_o is low after reset.
module sync_write_packet_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [6:0]  servo_count_i,
  input  logic [7:0]  reg_address_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] data_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        run_last_o,
  output logic        packet_end_o
);
  import swpf_pkg::*;

  burst_t burst;
  logic   can_load;
  logic   accept;

  // An input transfer happens whenever the shift register can take the
  // burst, even if the item turns out to produce no bytes.
  assign in_stall_o = !can_load;
  assign accept     = in_valid_i && can_load;

  swpf_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .servo_count_i (servo_count_i),
    .reg_address_i (reg_address_i),
    .servo_id_i    (servo_id_i),
    .data_value_i  (data_value_i),
    .burst_o       (burst)
  );

  swpf_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .burst_i      (burst),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .run_last_o   (run_last_o),
    .packet_end_o (packet_end_o)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the servo-bus sync-write packet framer.
module tb_top;
  import swpf_pkg::*;

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned ItemsPerPhase = 44;
  localparam int unsigned NumRows       = 20;

  // One packet byte as it leaves the framer.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       packet_end;
  } tx_beat_t;

  // One directed transfer. Where typed is set, the bytes are given here and
  // the framing model only tracks the checksum and open-packet state.
  typedef struct packed {
    op_e             op;
    logic [6:0]      count;
    logic [7:0]      addr;
    logic [7:0]      id;
    logic [15:0]     value;
    logic            typed;
    logic [3:0]      n_bytes;
    logic            ends;
    logic [0:7][7:0] bytes;
  } stim_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  op_e         operation   = OP_START;
  logic [6:0]  servo_count = '0;
  logic [7:0]  reg_address = '0;
  logic [7:0]  servo_id    = '0;
  logic [15:0] data_value  = '0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  tx_byte;
  logic        run_last;
  logic        packet_end;

  int sender_idle_pct = 9;
  int recv_idle_pct   = 57;
  int mismatch_count  = 0;
  int bytes_checked   = 0;
  int packets_closed  = 0;
  int items_sent      = 0;
  int items_framed    = 0;
  int quiet_cycles    = 0;

  // Framing model state: checksum accumulator and entries still announced.
  logic [7:0] sum_acc      = '0;
  logic [6:0] entries_open = '0;

  tx_beat_t expected_bytes[$];
  tx_beat_t fresh_bytes[$];

  // Directed part: empty-packet headers, checksum extremes, abandoned
  // packets, stray entries and the length byte wrapping past 255.
  stim_row_t directed_rows [NumRows] = '{
    '{OP_ENTRY, 7'd0,   8'h00, 8'h12, 16'h3456, 1'b1, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd0,   8'h00, 8'h00, 16'h0000, 1'b1, 4'd8, 1'b1, 64'hFFFF_FE04_8300_0278},
    '{OP_START, 7'd0,   8'hFF, 8'hFF, 16'hFFFF, 1'b1, 4'd8, 1'b1, 64'hFFFF_FE04_83FF_0279},
    '{OP_ENTRY, 7'd127, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd1,   8'h1E, 8'h00, 16'h0000, 1'b1, 4'd7, 1'b0, 64'hFFFF_FE07_831E_0200},
    '{OP_ENTRY, 7'd0,   8'h00, 8'hFF, 16'hFFFF, 1'b1, 4'd4, 1'b1, 64'hFFFF_FF5A_0000_0000},
    '{OP_START, 7'd2,   8'h00, 8'hC3, 16'h1234, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd5,   8'h11, 8'h00, 16'h0000, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd3,   8'h55, 8'h3C, 16'hA5A5, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd64,  8'h80, 8'h01, 16'h8000, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd0,   8'h00, 8'h80, 16'h00FF, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd0,   8'h00, 8'h7F, 16'h7F01, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd9,   8'h99, 8'h33, 16'hCCCC, 1'b1, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd84,  8'hAA, 8'h00, 16'h0000, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd127, 8'h01, 8'h00, 16'h0000, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd0,   8'h00, 8'hAA, 16'h5555, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd83,  8'h80, 8'h00, 16'h0000, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd0,   8'h00, 8'h55, 16'hAAAA, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_START, 7'd1,   8'h00, 8'h00, 16'h0000, 1'b0, 4'd0, 1'b0, 64'h0},
    '{OP_ENTRY, 7'd0,   8'h00, 8'h00, 16'h0000, 1'b0, 4'd0, 1'b0, 64'h0}
  };

  sync_write_packet_framer_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .servo_count_i(servo_count),
    .reg_address_i(reg_address),
    .servo_id_i   (servo_id),
    .data_value_i (data_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .tx_byte_o    (tx_byte),
    .run_last_o   (run_last),
    .packet_end_o (packet_end)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  function automatic void add_beat(logic [7:0] b, logic last, logic fin);
    tx_beat_t beat;
    beat = '{b, last, fin};
    fresh_bytes.push_back(beat);
  endfunction

  // Works out the bytes one input transfer causes and advances the checksum
  // and open-packet state. The result is left in fresh_bytes.
  function automatic void frame_item(op_e op, logic [6:0] count, logic [7:0] addr,
                                     logic [7:0] id, logic [15:0] value);
    logic [7:0] len;
    logic [7:0] sum;
    fresh_bytes.delete();
    if (op == OP_START) begin
      // The length byte wraps modulo 256 and the checksum uses the wrapped value.
      len = 8'(32'd3 * count + 32'd4);
      sum = BROADCAST_ID + len + INSTR_SYNC + addr + DATA_LEN;
      add_beat(HEADER_BYTE, 1'b0, 1'b0);
      add_beat(HEADER_BYTE, 1'b0, 1'b0);
      add_beat(BROADCAST_ID, 1'b0, 1'b0);
      add_beat(len, 1'b0, 1'b0);
      add_beat(INSTR_SYNC, 1'b0, 1'b0);
      add_beat(addr, 1'b0, 1'b0);
      add_beat(DATA_LEN, count != '0, 1'b0);
      if (count == '0) begin
        add_beat(~sum, 1'b1, 1'b1);
        sum_acc = '0;
      end else begin
        sum_acc = sum;
      end
      // A start always replaces whatever packet was open.
      entries_open = count;
    end else if (entries_open != '0) begin
      sum = sum_acc + id + value[15:8] + value[7:0];
      entries_open = entries_open - 7'd1;
      add_beat(id, 1'b0, 1'b0);
      add_beat(value[15:8], 1'b0, 1'b0);
      add_beat(value[7:0], entries_open != '0, 1'b0);
      if (entries_open == '0) begin
        add_beat(~sum, 1'b1, 1'b1);
        sum_acc = '0;
      end else begin
        sum_acc = sum;
      end
    end
  endfunction

  // Offers one item, with random idle cycles ahead of it, and waits for the
  // transfer. With keep_model set the framing model's bytes become expected.
  task automatic send_item(op_e op, logic [6:0] count, logic [7:0] addr,
                           logic [7:0] id, logic [15:0] value, bit keep_model);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    servo_count <= count;
    reg_address <= addr;
    servo_id    <= id;
    data_value  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_item(op, count, addr, id, value);
    items_sent++;
    if (fresh_bytes.size() != 0) items_framed++;
    if (keep_model) begin
      foreach (fresh_bytes[k]) expected_bytes.push_back(fresh_bytes[k]);
    end
  endtask

  // Random packets: mostly complete ones with small counts, some empty ones,
  // some abandoned early (large counts always are), and a few stray entries
  // after a closed packet.
  task automatic run_packets(int target);
    int         first;
    int         r;
    int         planned;
    logic [6:0] count;
    first = items_framed;
    while (items_framed - first < target) begin
      r = $urandom_range(99);
      if (r < 8) count = '0;
      else if (r < 14) count = 7'($urandom_range(127, 7));
      else count = 7'($urandom_range(6, 1));
      planned = count;
      if (count > 7'd6) planned = $urandom_range(6, 0);
      else if (r >= 14 && r < 24) planned = $urandom_range(count - 1, 0);
      send_item(OP_START, count, 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      repeat (planned)
        send_item(OP_ENTRY, 7'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      if (planned == count && $urandom_range(99) < 15) begin
        repeat ($urandom_range(2, 1))
          send_item(OP_ENTRY, 7'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      end
    end
  endtask

  // The sender holds off until every expected byte has been transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    tx_beat_t beat;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender rarely idles, receiver stalls often.
    sender_idle_pct = 9;
    recv_idle_pct   = 57;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].count, directed_rows[i].addr,
                directed_rows[i].id, directed_rows[i].value, !directed_rows[i].typed);
      if (directed_rows[i].typed) begin
        for (int k = 0; k < directed_rows[i].n_bytes; k++) begin
          beat.tx_byte    = directed_rows[i].bytes[k];
          beat.run_last   = (k == directed_rows[i].n_bytes - 1);
          beat.packet_end = directed_rows[i].ends && (k == directed_rows[i].n_bytes - 1);
          expected_bytes.push_back(beat);
        end
      end
    end
    run_packets(ItemsPerPhase);
    wait_drained();

    // Phase two: the other way round.
    sender_idle_pct = 57;
    recv_idle_pct   = 9;
    run_packets(ItemsPerPhase);
    wait_drained();

    // Phase three: full rate on both sides.
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    run_packets(ItemsPerPhase);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d input transfers, %0d of them producing bytes, over three stall mixes.",
             items_sent, items_framed);
    $display("Checked %0d packet bytes, %0d of them checksums.", bytes_checked, packets_closed);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // The receiver stalls at random with the current phase's rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Each byte transfer is compared with the oldest expected byte.
  always @(posedge clk) begin
    tx_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("tx_byte: no byte expected, got %02h", tx_byte);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (want.packet_end) packets_closed++;
        if (tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
          mismatch_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last);
          mismatch_count++;
        end
        if (packet_end !== want.packet_end) begin
          $error("packet_end: expected %0b, got %0b", want.packet_end, packet_end);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
